// ===== hw/rtl/ehp_pkg.sv =====
// shared types and constants for the ethernet header parser
package ehp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0]  vlan_tags;
    logic [1:0]  l3_kind;
    logic [2:0]  l4_kind;
    logic [7:0]  l4_protocol;
    logic [15:0] final_ethertype;
    logic [4:0]  l3_offset;
    logic [5:0]  l4_offset;
    logic [6:0]  payload_offset;
    logic        truncated;
  } out_t;

  // frame bytes that the parse can look at, by position in the frame
  localparam int unsigned NCAP = 17;
  localparam int unsigned CI_ET0_HI = 0;   // byte 12
  localparam int unsigned CI_ET0_LO = 1;   // byte 13
  localparam int unsigned CI_ET1_HI = 2;   // byte 16
  localparam int unsigned CI_ET1_LO = 3;   // byte 17
  localparam int unsigned CI_ET2_HI = 4;   // byte 20, also ipv6 next header with no tag
  localparam int unsigned CI_ET2_LO = 5;   // byte 21
  localparam int unsigned CI_P4_0   = 6;   // byte 23
  localparam int unsigned CI_P4_1   = 7;   // byte 27
  localparam int unsigned CI_P4_2   = 8;   // byte 31
  localparam int unsigned CI_P6_1   = 9;   // byte 24
  localparam int unsigned CI_P6_2   = 10;  // byte 28
  localparam int unsigned CI_DO4_0  = 11;  // byte 46
  localparam int unsigned CI_DO4_1  = 12;  // byte 50
  localparam int unsigned CI_DO4_2  = 13;  // byte 54
  localparam int unsigned CI_DO6_0  = 14;  // byte 66
  localparam int unsigned CI_DO6_1  = 15;  // byte 70
  localparam int unsigned CI_DO6_2  = 16;  // byte 74

  localparam logic [NCAP-1:0][7:0] CAP_POS = {
    8'd74, 8'd70, 8'd66, 8'd54, 8'd50, 8'd46, 8'd28, 8'd24,
    8'd31, 8'd27, 8'd23, 8'd21, 8'd20, 8'd17, 8'd16, 8'd13, 8'd12
  };

  typedef logic [NCAP-1:0][7:0] cap_t;

  localparam logic [15:0] ET_IP4 = 16'h0800;
  localparam logic [15:0] ET_IP6 = 16'h86DD;
  localparam logic [15:0] ET_ARP = 16'h0806;
  localparam logic [15:0] ET_TAG = 16'h8100;

  localparam logic [7:0] PR_TCP   = 8'd6;
  localparam logic [7:0] PR_UDP   = 8'd17;
  localparam logic [7:0] PR_ICMP4 = 8'd1;
  localparam logic [7:0] PR_ICMP6 = 8'd58;

  localparam logic [1:0] L3_NONE = 2'd0;
  localparam logic [1:0] L3_IP4  = 2'd1;
  localparam logic [1:0] L3_IP6  = 2'd2;
  localparam logic [1:0] L3_ARP  = 2'd3;

  localparam logic [2:0] L4_NONE  = 3'd0;
  localparam logic [2:0] L4_TCP   = 3'd1;
  localparam logic [2:0] L4_UDP   = 3'd2;
  localparam logic [2:0] L4_ICMP4 = 3'd3;
  localparam logic [2:0] L4_ICMP6 = 3'd4;

  localparam logic [4:0] MAC_LEN = 5'd14;
  localparam logic [4:0] TAG_LEN = 5'd4;
  localparam logic [6:0] IP4_LEN = 7'd20;
  localparam logic [6:0] IP6_LEN = 7'd40;
  localparam logic [6:0] UDP_LEN = 7'd8;

endpackage

// ===== hw/rtl/ethernet_header_parser.sv =====
// top level: byte stream capture and per-frame header summary
// the summary is registered and valid in the cycle after the last byte of a frame is accepted
// throughput: one byte per cycle, set by the capture registers and the single decode stage
// the input stalls only while a summary is held and out_ready_i is low
// reset (rst_ni low, asynchronous) empties the output register and clears the frame capture
module ethernet_header_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ehp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ehp_pkg::out_t out_data_o
);

  ehp_pkg::cap_t cap_q, cap_d, cap_now;
  logic [7:0]    cnt_q, cnt_d, cnt_inc;
  logic          out_valid_q, out_valid_d;
  ehp_pkg::out_t out_q, out_d, sum;
  logic          in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cnt_inc    = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;

  // capture view including the byte on the input now
  always_comb begin
    cap_now = cap_q;
    for (int i = 0; i < ehp_pkg::NCAP; i++) begin
      if (cnt_q == ehp_pkg::CAP_POS[i]) cap_now[i] = in_data_i.data_byte;
    end
  end

  ehp_hdr_decode u_decode (
    .cap_i      (cap_now),
    .byte_cnt_i (cnt_inc),
    .sum_o      (sum)
  );

  always_comb begin
    cap_d       = cap_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire) begin
      if (in_data_i.last) begin
        cap_d       = '0;
        cnt_d       = 8'd0;
        out_d       = sum;
        out_valid_d = 1'b1;
      end else begin
        cap_d = cap_now;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      cnt_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/ehp_hdr_decode.sv =====
// header decode of one frame from its captured bytes
module ehp_hdr_decode (
  input  ehp_pkg::cap_t cap_i,
  input  logic [7:0]    byte_cnt_i,
  output ehp_pkg::out_t sum_o
);

  logic [15:0] et0, et1, et2;
  logic [1:0]  tags;
  logic [15:0] et;
  logic [4:0]  noff;
  logic        stopped;
  logic        is_ip, is_v6;
  logic [1:0]  kind;
  logic [7:0]  proto;
  logic [3:0]  nib;
  logic [6:0]  cur, at;
  logic [2:0]  l4k;

  assign et0 = {cap_i[ehp_pkg::CI_ET0_HI], cap_i[ehp_pkg::CI_ET0_LO]};
  assign et1 = {cap_i[ehp_pkg::CI_ET1_HI], cap_i[ehp_pkg::CI_ET1_LO]};
  assign et2 = {cap_i[ehp_pkg::CI_ET2_HI], cap_i[ehp_pkg::CI_ET2_LO]};

  always_comb begin
    stopped = 1'b0;
    if (et0 != ehp_pkg::ET_TAG) begin
      tags = 2'd0;
      et   = et0;
    end else if (et1 != ehp_pkg::ET_TAG) begin
      tags = 2'd1;
      et   = et1;
    end else begin
      tags    = 2'd2;
      et      = et2;
      // third tag ends the parse
      stopped = (et2 == ehp_pkg::ET_TAG);
    end
    noff = ehp_pkg::MAC_LEN + 5'(tags * ehp_pkg::TAG_LEN);

    kind  = ehp_pkg::L3_NONE;
    is_ip = 1'b0;
    is_v6 = 1'b0;
    if (!stopped) begin
      if (et == ehp_pkg::ET_IP4) begin
        kind  = ehp_pkg::L3_IP4;
        is_ip = 1'b1;
      end else if (et == ehp_pkg::ET_IP6) begin
        kind  = ehp_pkg::L3_IP6;
        is_ip = 1'b1;
        is_v6 = 1'b1;
      end else if (et == ehp_pkg::ET_ARP) begin
        kind = ehp_pkg::L3_ARP;
      end
    end

    case ({is_v6, tags})
      3'b000:  proto = cap_i[ehp_pkg::CI_P4_0];
      3'b001:  proto = cap_i[ehp_pkg::CI_P4_1];
      3'b010:  proto = cap_i[ehp_pkg::CI_P4_2];
      3'b100:  proto = cap_i[ehp_pkg::CI_ET2_HI];
      3'b101:  proto = cap_i[ehp_pkg::CI_P6_1];
      3'b110:  proto = cap_i[ehp_pkg::CI_P6_2];
      default: proto = 8'd0;
    endcase
    if (!is_ip) proto = 8'd0;

    case ({is_v6, tags})
      3'b000:  nib = cap_i[ehp_pkg::CI_DO4_0][7:4];
      3'b001:  nib = cap_i[ehp_pkg::CI_DO4_1][7:4];
      3'b010:  nib = cap_i[ehp_pkg::CI_DO4_2][7:4];
      3'b100:  nib = cap_i[ehp_pkg::CI_DO6_0][7:4];
      3'b101:  nib = cap_i[ehp_pkg::CI_DO6_1][7:4];
      3'b110:  nib = cap_i[ehp_pkg::CI_DO6_2][7:4];
      default: nib = 4'd0;
    endcase

    if (stopped) begin
      cur = {2'b00, noff} + {2'b00, ehp_pkg::TAG_LEN};
    end else if (is_v6) begin
      cur = {2'b00, noff} + ehp_pkg::IP6_LEN;
    end else if (is_ip) begin
      cur = {2'b00, noff} + ehp_pkg::IP4_LEN;
    end else begin
      cur = {2'b00, noff};
    end
    at = cur;

    l4k = ehp_pkg::L4_NONE;
    if (is_ip) begin
      if (proto == ehp_pkg::PR_TCP) begin
        l4k = ehp_pkg::L4_TCP;
        cur = at + {1'b0, nib, 2'b00};
      end else if (proto == ehp_pkg::PR_UDP) begin
        l4k = ehp_pkg::L4_UDP;
        cur = at + ehp_pkg::UDP_LEN;
      end else if (proto == ehp_pkg::PR_ICMP4) begin
        l4k = ehp_pkg::L4_ICMP4;
      end else if (proto == ehp_pkg::PR_ICMP6) begin
        l4k = ehp_pkg::L4_ICMP6;
      end
    end

    sum_o.vlan_tags       = tags;
    sum_o.l3_kind         = kind;
    sum_o.l4_kind         = l4k;
    sum_o.l4_protocol     = proto;
    sum_o.final_ethertype = et;
    sum_o.l3_offset       = noff;
    sum_o.l4_offset       = (l4k != ehp_pkg::L4_NONE) ? at[5:0] : 6'd0;
    sum_o.payload_offset  = cur;
    sum_o.truncated       = (byte_cnt_i < {1'b0, cur});
  end

endmodule

// ===== hw/rtl/ehp_checker.sv =====
// port-level checks for the ethernet header parser, bound to the top level
module ehp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ehp_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ehp_pkg::out_t out_data_o
);

  // a held summary keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("summary changed while stalled");

  // the last byte of a frame gives a summary in the next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> out_valid_o)
    else $error("no summary after last byte");

  a_l3_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.l3_offset ==
      5'(5'd14 + 5'(out_data_o.vlan_tags) * 5'd4))
    else $error("network offset does not match tag count");

  // no transport offset without a recognized transport
  a_l4_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.l4_kind == ehp_pkg::L4_NONE |-> out_data_o.l4_offset == 6'd0)
    else $error("transport offset without transport kind");

  a_no_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.l3_kind == ehp_pkg::L3_NONE ||
                    out_data_o.l3_kind == ehp_pkg::L3_ARP)
      |-> out_data_o.l4_protocol == 8'd0 && out_data_o.l4_kind == ehp_pkg::L4_NONE)
    else $error("transport fields set without ip");

endmodule

bind ethernet_header_parser ehp_checker u_ehp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_ethernet_header_parser.sv =====
// testbench for the ethernet header parser: random and directed frames checked against a predictor
`timescale 1ns / 1ps

module tb_ethernet_header_parser;

  localparam int unsigned CAP_DEPTH = 128;
  localparam int unsigned FRAME_BUF = 300;
  localparam int unsigned N_ITEMS   = 1550;

  typedef enum int {NET_IP4, NET_IP6, NET_ARP, NET_RAND, NET_RAW} net_sel_e;
  typedef enum int {LEN_FULL, LEN_SHORT, LEN_LONG, LEN_ONE, LEN_HUGE} len_sel_e;
  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct {
    ehp_pkg::in_t beat;
    int unsigned  gap;
    bit           drain;
  } byte_item_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  ehp_pkg::in_t  in_data_i   = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  ehp_pkg::out_t out_data_o;

  byte_item_t    byte_queue[$];
  ehp_pkg::out_t expected_summaries[$];
  logic          in_took  = 1'b0;
  logic          out_took = 1'b0;
  int unsigned   wait_left = 0;
  int unsigned   hold_left = 0;
  int unsigned   fail_count = 0;

  // predictor state for the frame in progress
  logic [7:0]  frame_cap [CAP_DEPTH];
  int unsigned frame_len = 0;

  ethernet_header_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] peek8(int unsigned pos);
    return (pos < CAP_DEPTH) ? frame_cap[pos] : 8'h00;
  endfunction

  function automatic ehp_pkg::out_t summarize_frame();
    ehp_pkg::out_t s;
    logic [15:0]   et;
    logic [7:0]    proto;
    logic [1:0]    l3k;
    logic [2:0]    l4k;
    int unsigned   cur, tags, l3off, l4at;
    bit            stopped;
    proto   = 8'h00;
    l3k     = ehp_pkg::L3_NONE;
    l4k     = ehp_pkg::L4_NONE;
    l4at    = 0;
    stopped = 1'b0;
    tags    = 0;
    cur     = ehp_pkg::MAC_LEN;
    l3off   = ehp_pkg::MAC_LEN;
    et      = {peek8(12), peek8(13)};
    while (et == ehp_pkg::ET_TAG && !stopped) begin
      if (tags >= 2) begin
        cur += ehp_pkg::TAG_LEN;
        stopped = 1'b1;
      end else begin
        et = {peek8(cur + 2), peek8(cur + 3)};
        cur += ehp_pkg::TAG_LEN;
        tags++;
        l3off = cur;
      end
    end
    if (!stopped) begin
      if (et == ehp_pkg::ET_IP4) begin
        l3k   = ehp_pkg::L3_IP4;
        proto = peek8(l3off + 9);
        cur  += ehp_pkg::IP4_LEN;
      end else if (et == ehp_pkg::ET_IP6) begin
        l3k   = ehp_pkg::L3_IP6;
        proto = peek8(l3off + 6);
        cur  += ehp_pkg::IP6_LEN;
      end else if (et == ehp_pkg::ET_ARP) begin
        l3k = ehp_pkg::L3_ARP;
      end
      if (l3k == ehp_pkg::L3_IP4 || l3k == ehp_pkg::L3_IP6) begin
        l4at = cur;
        if (proto == ehp_pkg::PR_TCP) begin
          l4k  = ehp_pkg::L4_TCP;
          cur += 4 * int'(peek8(l4at + 12) >> 4);
        end else if (proto == ehp_pkg::PR_UDP) begin
          l4k  = ehp_pkg::L4_UDP;
          cur += ehp_pkg::UDP_LEN;
        end else if (proto == ehp_pkg::PR_ICMP4) begin
          l4k = ehp_pkg::L4_ICMP4;
        end else if (proto == ehp_pkg::PR_ICMP6) begin
          l4k = ehp_pkg::L4_ICMP6;
        end
        if (l4k == ehp_pkg::L4_NONE) l4at = 0;
      end
    end
    s.vlan_tags       = 2'(tags);
    s.l3_kind         = l3k;
    s.l4_kind         = l4k;
    s.l4_protocol     = proto;
    s.final_ethertype = et;
    s.l3_offset       = 5'(l3off);
    s.l4_offset       = 6'(l4at);
    s.payload_offset  = 7'(cur);
    s.truncated       = (frame_len < cur);
    return s;
  endfunction

  task automatic absorb_byte(input ehp_pkg::in_t b);
    if (frame_len < CAP_DEPTH) frame_cap[frame_len] = b.data_byte;
    if (frame_len < 255) frame_len++;
    if (b.last) begin
      expected_summaries.push_back(summarize_frame());
      for (int i = 0; i < CAP_DEPTH; i++) frame_cap[i] = 8'h00;
      frame_len = 0;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h) actual %0d (0x%0h)",
               $time, name, want, want, got, got);
      fail_count++;
    end
  endtask

  // build one frame from a header layout and push its bytes to the driver queue
  task automatic queue_frame(input int unsigned tags, input net_sel_e net,
                             input logic [7:0] proto, input logic [3:0] tcp_words,
                             input len_sel_e lsel, input fill_e fill,
                             input bit drain, input bit burst);
    logic [7:0]  fb [FRAME_BUF];
    logic [15:0] et_word;
    int unsigned l3, hdr_end, len;
    byte_item_t  bi;
    for (int i = 0; i < FRAME_BUF; i++) begin
      fb[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    end
    l3      = ehp_pkg::MAC_LEN + ehp_pkg::TAG_LEN * ((tags > 2) ? 2 : tags);
    hdr_end = l3;
    if (net != NET_RAW) begin
      for (int t = 0; t < tags; t++) begin
        fb[12 + 4 * t] = ehp_pkg::ET_TAG[15:8];
        fb[13 + 4 * t] = ehp_pkg::ET_TAG[7:0];
      end
      if (tags > 2) begin
        hdr_end = l3 + ehp_pkg::TAG_LEN;
      end else begin
        case (net)
          NET_IP4: begin
            et_word   = ehp_pkg::ET_IP4;
            fb[l3 + 9] = proto;
            hdr_end   = l3 + ehp_pkg::IP4_LEN;
          end
          NET_IP6: begin
            et_word   = ehp_pkg::ET_IP6;
            fb[l3 + 6] = proto;
            hdr_end   = l3 + ehp_pkg::IP6_LEN;
          end
          NET_ARP: et_word = ehp_pkg::ET_ARP;
          default: et_word = 16'($urandom);
        endcase
        fb[l3 - 2] = et_word[15:8];
        fb[l3 - 1] = et_word[7:0];
        if (net == NET_IP4 || net == NET_IP6) begin
          if (proto == ehp_pkg::PR_TCP) begin
            fb[hdr_end + 12] = {tcp_words, fb[hdr_end + 12][3:0]};
            hdr_end += 4 * tcp_words;
          end else if (proto == ehp_pkg::PR_UDP) begin
            hdr_end += ehp_pkg::UDP_LEN;
          end
        end
      end
    end
    case (lsel)
      LEN_FULL:  len = hdr_end + $urandom_range(0, 12);
      LEN_SHORT: len = $urandom_range(1, hdr_end - 1);
      LEN_LONG:  len = $urandom_range(129, 170);
      LEN_ONE:   len = 1;
      default:   len = 260;
    endcase
    for (int i = 0; i < len; i++) begin
      bi.beat.data_byte = fb[i];
      bi.beat.last      = (i == len - 1);
      bi.gap            = burst ? 0 :
                          (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
      bi.drain          = drain && (i == 0);
      byte_queue.push_back(bi);
    end
  endtask

  // driver: next byte at the falling edge once the previous transaction is done
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (byte_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (byte_queue[0].drain && expected_summaries.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (wait_left < byte_queue[0].gap) begin
        in_valid_i <= 1'b0;
        wait_left  <= wait_left + 1;
      end else begin
        in_data_i  <= byte_queue[0].beat;
        in_valid_i <= 1'b1;
        wait_left  <= 0;
        byte_queue.delete(0);
      end
    end
  end

  // receiver: random stall after each summary transaction
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: check the summary first, then feed the accepted byte to the predictor
  always @(posedge clk_i) begin : monitor
    ehp_pkg::out_t want;
    in_took  <= in_valid_i && in_ready_o;
    out_took <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t: summary with none expected, expected nothing actual %p",
                   $time, out_data_o);
          fail_count++;
        end else begin
          want = expected_summaries.pop_front();
          compare_field("vlan_tags", want.vlan_tags, out_data_o.vlan_tags);
          compare_field("l3_kind", want.l3_kind, out_data_o.l3_kind);
          compare_field("l4_kind", want.l4_kind, out_data_o.l4_kind);
          compare_field("l4_protocol", want.l4_protocol, out_data_o.l4_protocol);
          compare_field("final_ethertype", want.final_ethertype,
                        out_data_o.final_ethertype);
          compare_field("l3_offset", want.l3_offset, out_data_o.l3_offset);
          compare_field("l4_offset", want.l4_offset, out_data_o.l4_offset);
          compare_field("payload_offset", want.payload_offset, out_data_o.payload_offset);
          compare_field("truncated", want.truncated, out_data_o.truncated);
        end
      end
      if (in_valid_i && in_ready_o) absorb_byte(in_data_i);
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned r, tags;
    net_sel_e    net;
    len_sel_e    lsel;
    logic [7:0]  proto;
    for (int i = 0; i < CAP_DEPTH; i++) frame_cap[i] = 8'h00;

    // directed frames
    queue_frame(0, NET_RAW, 8'h00, 4'd0, LEN_FULL, FILL_ZERO, 1'b0, 1'b1);
    queue_frame(0, NET_RAW, 8'h00, 4'd0, LEN_FULL, FILL_ONES, 1'b0, 1'b0);
    queue_frame(0, NET_RAW, 8'h00, 4'd0, LEN_ONE, FILL_ONES, 1'b0, 1'b0);
    queue_frame(0, NET_RAW, 8'h00, 4'd0, LEN_ONE, FILL_ZERO, 1'b0, 1'b0);
    queue_frame(0, NET_IP4, ehp_pkg::PR_TCP, 4'd5, LEN_FULL, FILL_RAND, 1'b0, 1'b1);
    queue_frame(2, NET_IP4, ehp_pkg::PR_TCP, 4'd15, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(0, NET_IP4, ehp_pkg::PR_TCP, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(1, NET_IP6, ehp_pkg::PR_UDP, 4'd0, LEN_FULL, FILL_RAND, 1'b1, 1'b0);
    queue_frame(2, NET_IP6, ehp_pkg::PR_TCP, 4'd15, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(0, NET_IP4, ehp_pkg::PR_ICMP4, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(1, NET_IP6, ehp_pkg::PR_ICMP6, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    // icmp kind follows the protocol byte, not the ip version
    queue_frame(0, NET_IP4, ehp_pkg::PR_ICMP6, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(0, NET_IP6, ehp_pkg::PR_ICMP4, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(1, NET_ARP, 8'h00, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(0, NET_RAND, 8'h00, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(3, NET_IP4, ehp_pkg::PR_TCP, 4'd5, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(0, NET_IP4, 8'd99, 4'd0, LEN_FULL, FILL_RAND, 1'b0, 1'b0);
    queue_frame(0, NET_IP4, ehp_pkg::PR_TCP, 4'd10, LEN_SHORT, FILL_RAND, 1'b0, 1'b0);
    queue_frame(2, NET_IP6, ehp_pkg::PR_UDP, 4'd0, LEN_LONG, FILL_RAND, 1'b0, 1'b1);
    // long enough to saturate the byte counter
    queue_frame(0, NET_IP4, ehp_pkg::PR_UDP, 4'd0, LEN_HUGE, FILL_RAND, 1'b1, 1'b1);

    // random frames, mostly well formed headers with random content
    while (byte_queue.size() < N_ITEMS) begin
      lsel = LEN_FULL;
      r = $urandom_range(0, 99);
      if (r < 70) lsel = LEN_FULL;
      else if (r < 95) lsel = LEN_SHORT;
      else lsel = LEN_LONG;
      if ($urandom_range(0, 99) < 15) begin
        queue_frame(0, NET_RAW, 8'h00, 4'd0, (lsel == LEN_FULL) ? LEN_SHORT : lsel,
                    FILL_RAND, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      end else begin
        r = $urandom_range(0, 9);
        tags = (r < 4) ? 0 : (r < 6) ? 1 : (r < 9) ? 2 : 3;
        r = $urandom_range(0, 99);
        if (r < 35) net = NET_IP4;
        else if (r < 65) net = NET_IP6;
        else if (r < 80) net = NET_ARP;
        else net = NET_RAND;
        r = $urandom_range(0, 99);
        if (r < 30) proto = ehp_pkg::PR_TCP;
        else if (r < 55) proto = ehp_pkg::PR_UDP;
        else if (r < 65) proto = ehp_pkg::PR_ICMP4;
        else if (r < 75) proto = ehp_pkg::PR_ICMP6;
        else proto = 8'($urandom);
        queue_frame(tags, net, proto, 4'($urandom), lsel, FILL_RAND,
                    $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_summaries.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_summaries.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
